// ----- design/sfat_pkg.sv -----
// ----------------------------------------------------------------------------
// sfat_pkg
// Shared types and constants of the shift fill adaptation table.
// ----------------------------------------------------------------------------
package sfat_pkg;

   localparam int NUM_BANDS = 4;
   localparam int BAND_W    = 2;
   localparam int ADDER_W   = 16;

   localparam logic signed [ADDER_W:0] ADDER_MAX = 17'sd32767;
   localparam logic signed [ADDER_W:0] INC_LARGE = 17'sd20;
   localparam logic signed [ADDER_W:0] INC_SMALL = 17'sd10;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADAPT  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_SPARE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_RPM_HIGH = 3'd2,
      ST_TEMP_OUT = 3'd3,
      ST_NO_CELL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_BEFORE_FILL = 3'd0,
      PH_FILL        = 3'd1,
      PH_OVERLAP     = 3'd2,
      PH_AFTER       = 3'd3,
      PH_BOUNDARY    = 3'd4,
      PH_NONE        = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      REG_MAX_TORQUE  = 3'd0,
      REG_RPM_LIMIT   = 3'd1,
      REG_TEMP_LOW    = 3'd2,
      REG_TEMP_HIGH   = 3'd3,
      REG_DEF_SPC     = 3'd4,
      REG_DEF_MPC     = 3'd5,
      REG_DEF_TIME    = 3'd6,
      REG_UNUSED      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [ADDER_W-1:0] spc;
      logic signed [ADDER_W-1:0] mpc;
      logic signed [ADDER_W-1:0] tim;
   } cell_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the request fields
      logic eval;   // select cell, run checks, read the cell
      logic apply;  // update the cell and register the response
   } ctrl_cmd_type;

endpackage

// ----- design/sfat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfat_ctrl
// Sequencer: capture, evaluate, apply, then present the response strobe.
// ----------------------------------------------------------------------------
module sfat_ctrl
   import sfat_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_APPLY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EVAL;
               busy_in  = 1'b1;
            end
         end
         S_EVAL: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            state_in     = S_IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = (state_ff == S_IDLE) && start;
   assign cmd.eval  = (state_ff == S_EVAL);
   assign cmd.apply = (state_ff == S_APPLY);

endmodule

// ----- design/sfat_dpath.sv -----
// ----------------------------------------------------------------------------
// sfat_dpath
// Datapath: settings registers, cell memory, checks, phases and adder update.
// ----------------------------------------------------------------------------
module sfat_dpath
   import sfat_pkg::*;
#(
   parameter int NUM_CHANGES = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic [1:0]          req_cmd,
   input  logic [3:0]          req_change_code,
   input  logic signed [15:0]  req_static_torque,
   input  logic [15:0]         req_engine_speed,
   input  logic signed [8:0]   req_fluid_temp,
   input  logic                req_report_ok,
   input  logic [15:0]         req_bleed_ms,
   input  logic [15:0]         req_fill_ms,
   input  logic [15:0]         req_overlap_ms,
   input  logic [15:0]         req_start_time,
   input  logic [15:0]         req_flare_time,
   output logic [2:0]          rsp_status,
   output logic                rsp_cell_hit,
   output logic signed [15:0]  rsp_spc_adder,
   output logic signed [15:0]  rsp_mpc_adder,
   output logic signed [15:0]  rsp_time_adder,
   output logic [2:0]          rsp_start_phase,
   output logic [2:0]          rsp_flare_phase
);

   localparam int NUM_CELLS = NUM_CHANGES * NUM_BANDS;
   localparam int IDX_W     = $clog2(NUM_CELLS);

   // Settings registers
   logic [15:0]        max_torque_ff;
   logic [15:0]        rpm_limit_ff;
   logic signed [8:0]  temp_low_ff;
   logic signed [8:0]  temp_high_ff;
   cell_type           def_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_torque_ff <= 16'd400;
         rpm_limit_ff  <= 16'd2500;
         temp_low_ff   <= 9'sd60;
         temp_high_ff  <= 9'sd110;
         def_ff        <= '0;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_MAX_TORQUE: max_torque_ff <= csr_data;
            REG_RPM_LIMIT:  rpm_limit_ff  <= csr_data;
            REG_TEMP_LOW:   temp_low_ff   <= csr_data[8:0];
            REG_TEMP_HIGH:  temp_high_ff  <= csr_data[8:0];
            REG_DEF_SPC:    def_ff.spc    <= csr_data;
            REG_DEF_MPC:    def_ff.mpc    <= csr_data;
            REG_DEF_TIME:   def_ff.tim    <= csr_data;
            default: ;
         endcase
      end
   end

   // Captured request
   cmd_type            cmd_ff;
   logic [3:0]         change_ff;
   logic signed [15:0] torque_ff;
   logic [15:0]        rpm_ff;
   logic signed [8:0]  temp_ff;
   logic               ok_ff;
   logic [15:0]        bleed_ff, fill_ff, ovl_ff, start_ff, flare_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= cmd_type'(req_cmd);
         change_ff <= req_change_code;
         torque_ff <= req_static_torque;
         rpm_ff    <= req_engine_speed;
         temp_ff   <= req_fluid_temp;
         ok_ff     <= req_report_ok;
         bleed_ff  <= req_bleed_ms;
         fill_ff   <= req_fill_ms;
         ovl_ff    <= req_overlap_ms;
         start_ff  <= req_start_time;
         flare_ff  <= req_flare_time;
      end
   end

   // Cell selection
   logic [13:0]      quarter;
   logic [15:0]      q2, q3;
   logic [15:0]      tq;
   logic [BAND_W-1:0] band;
   logic             band_hit, row_hit, hit;
   logic [IDX_W-1:0] idx_in;

   assign quarter = max_torque_ff[15:2];
   assign q2      = {1'b0, quarter, 1'b0};
   assign q3      = {2'b00, quarter} + q2;
   assign tq      = torque_ff;

   always_comb begin
      band     = '0;
      band_hit = 1'b1;
      if (torque_ff <= 16'sd0) begin
         band = BAND_W'(0);
      end else if (tq <= {2'b00, quarter}) begin
         band = BAND_W'(1);
      end else if (tq <= q2) begin
         band = BAND_W'(2);
      end else if (tq <= q3) begin
         band = BAND_W'(3);
      end else begin
         band_hit = 1'b0;
      end
   end

   assign row_hit = {1'b0, change_ff} < 5'(NUM_CHANGES);
   assign hit     = row_hit && band_hit;
   assign idx_in  = hit ? ((IDX_W'(change_ff) << BAND_W) | IDX_W'(band)) : '0;

   // Phase placement against the boundaries
   logic [16:0] b_ovl;
   logic [17:0] b_max;

   assign b_ovl = {1'b0, bleed_ff} + {1'b0, fill_ff};
   assign b_max = {1'b0, b_ovl} + {2'b00, ovl_ff};

   function automatic phase_type phase_of(input logic [15:0] t, input logic [15:0] f,
                                          input logic [16:0] o, input logic [17:0] m);
      phase_type p;
      if (t < f) begin
         p = PH_BEFORE_FILL;
      end else if ({1'b0, t} < o) begin
         p = PH_FILL;
      end else if ({2'b00, t} < m) begin
         p = PH_OVERLAP;
      end else if ({2'b00, t} > m) begin
         p = PH_AFTER;
      end else begin
         p = PH_BOUNDARY;
      end
      return p;
   endfunction

   // Status of the item
   status_type st_in;
   always_comb begin
      case (cmd_ff)
         CMD_CLEAR: st_in = ST_OK;
         CMD_ADAPT: begin
            if (!ok_ff) begin
               st_in = ST_INVALID;
            end else if (rpm_ff > rpm_limit_ff) begin
               st_in = ST_RPM_HIGH;
            end else if (temp_ff < temp_low_ff || temp_ff > temp_high_ff) begin
               st_in = ST_TEMP_OUT;
            end else if (!hit) begin
               st_in = ST_NO_CELL;
            end else begin
               st_in = ST_OK;
            end
         end
         default: st_in = hit ? ST_OK : ST_NO_CELL;
      endcase
   end

   status_type       st_ff;
   logic             use_cell_ff;
   logic             flare_on_ff;
   phase_type        sp_ff, fp_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         st_ff       <= st_in;
         use_cell_ff <= (st_in == ST_OK) && (cmd_ff != CMD_CLEAR);
         flare_on_ff <= (flare_ff != 16'd0);
         sp_ff       <= phase_of(start_ff, bleed_ff, b_ovl, b_max);
         fp_ff       <= phase_of(flare_ff, bleed_ff, b_ovl, b_max);
         idx_ff      <= idx_in;
      end
   end

   // Cell memory; a cell without its valid bit reads as the clear value
   cell_type               mem [NUM_CELLS];
   cell_type               rd_data_ff;
   logic                   rd_valid_ff;
   logic [NUM_CELLS-1:0]   valid_ff;
   cell_type               clr_val_ff;
   cell_type               cur, upd;
   logic                   wr_en;

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rd_data_ff  <= mem[idx_in];
         rd_valid_ff <= valid_ff[idx_in];
      end
      if (wr_en) begin
         mem[idx_ff] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         clr_val_ff <= '0;
      end else if (cmd.apply && cmd_ff == CMD_CLEAR) begin
         valid_ff   <= '0;
         clr_val_ff <= def_ff;
      end else if (wr_en) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                  input logic signed [16:0] b);
      logic signed [16:0] s;
      s = 17'(a) + b;
      return (s > ADDER_MAX) ? ADDER_MAX[15:0] : s[15:0];
   endfunction

   assign cur = rd_valid_ff ? rd_data_ff : clr_val_ff;

   always_comb begin
      upd = cur;
      if (sp_ff == PH_BEFORE_FILL) begin
         if (flare_on_ff) begin
            upd.mpc = sat_add(cur.mpc, INC_LARGE);
         end else begin
            upd.tim = sat_add(cur.tim, INC_SMALL);
         end
      end else if (sp_ff == PH_AFTER) begin
         upd.spc = sat_add(cur.spc, INC_LARGE);
      end
   end

   assign wr_en = cmd.apply && use_cell_ff && (cmd_ff == CMD_ADAPT);

   // Response registers
   logic               adapt_hit;
   cell_type           rsp_cell_in;
   phase_type          rsp_sp_in, rsp_fp_in;

   assign adapt_hit   = use_cell_ff && (cmd_ff == CMD_ADAPT);
   assign rsp_cell_in = !use_cell_ff ? def_ff : (adapt_hit ? upd : cur);
   assign rsp_sp_in   = adapt_hit ? sp_ff : PH_NONE;
   assign rsp_fp_in   = (adapt_hit && flare_on_ff) ? fp_ff : PH_NONE;

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_status      <= st_ff;
         rsp_cell_hit    <= use_cell_ff;
         rsp_spc_adder   <= rsp_cell_in.spc;
         rsp_mpc_adder   <= rsp_cell_in.mpc;
         rsp_time_adder  <= rsp_cell_in.tim;
         rsp_start_phase <= rsp_sp_in;
         rsp_flare_phase <= rsp_fp_in;
      end
   end

endmodule

// ----- design/shift_fill_adaptation_table_unit.sv -----
// ----------------------------------------------------------------------------
// shift_fill_adaptation_table_unit
// Table of fill adders per gear change and torque band, with lookup,
// adaptation from shift reports and clear to defaults.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_* and raise start; the transfer happens at
//    the clock edge where start is high and busy is low.
//  - Each command runs in order: the transfer edge captures the request,
//    the evaluate state selects the cell, runs the checks and reads the
//    cell memory, and the apply state updates the cell and registers the
//    response. rsp_valid is high for exactly one cycle right after that;
//    busy is low in the same cycle, so the next request may transfer then.
//    A new command is taken only once the last is through, as set by the
//    registered read of the single-port cell memory and its read-modify-write.
//  - Clear runs the same steps: it drops every cell's valid bit and
//    latches the default adders as the value that unwritten cells read as.
//  - Settings port: csr_valid/csr_ready with csr_index and csr_data; always
//    ready. Write only while no command is in flight; unused indexes drop.
//  - Reset (synchronous): settings return to their reset values and every
//    cell reads as zero; no sweep is needed.
//  - The receiver cannot stall: capture rsp_* whenever rsp_valid is high.
// ----------------------------------------------------------------------------
module shift_fill_adaptation_table_unit
   import sfat_pkg::*;
#(
   parameter int NUM_CHANGES = 8
)
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic [3:0]          req_change_code,
   input  logic signed [15:0]  req_static_torque,
   input  logic [15:0]         req_engine_speed,
   input  logic signed [8:0]   req_fluid_temp,
   input  logic                req_report_ok,
   input  logic [15:0]         req_bleed_ms,
   input  logic [15:0]         req_fill_ms,
   input  logic [15:0]         req_overlap_ms,
   input  logic [15:0]         req_start_time,
   input  logic [15:0]         req_flare_time,
   // response channel
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_cell_hit,
   output logic signed [15:0]  rsp_spc_adder,
   output logic signed [15:0]  rsp_mpc_adder,
   output logic signed [15:0]  rsp_time_adder,
   output logic [2:0]          rsp_start_phase,
   output logic [2:0]          rsp_flare_phase,
   // settings port
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);

   ctrl_cmd_type cmd;

   // Settings writes are accepted as soon as they are offered; always ready.
   assign csr_ready = 1'b1;

   sfat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   sfat_dpath #(
      .NUM_CHANGES (NUM_CHANGES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_cmd           (req_cmd),
      .req_change_code   (req_change_code),
      .req_static_torque (req_static_torque),
      .req_engine_speed  (req_engine_speed),
      .req_fluid_temp    (req_fluid_temp),
      .req_report_ok     (req_report_ok),
      .req_bleed_ms      (req_bleed_ms),
      .req_fill_ms       (req_fill_ms),
      .req_overlap_ms    (req_overlap_ms),
      .req_start_time    (req_start_time),
      .req_flare_time    (req_flare_time),
      .rsp_status        (rsp_status),
      .rsp_cell_hit      (rsp_cell_hit),
      .rsp_spc_adder     (rsp_spc_adder),
      .rsp_mpc_adder     (rsp_mpc_adder),
      .rsp_time_adder    (rsp_time_adder),
      .rsp_start_phase   (rsp_start_phase),
      .rsp_flare_phase   (rsp_flare_phase)
   );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shift fill adaptation table unit. A scoreboard
// object keeps its own copy of the adder table and the settings, works out
// the response of every request the unit takes, and checks each response
// strobe against the oldest outstanding one. A directed opener is followed
// by random traffic in four phases with different settings and idling.
// ----------------------------------------------------------------------------
module tb
   import sfat_pkg::*;
();

   typedef struct {
      cmd_type            cmd;
      logic [3:0]         change;
      logic signed [15:0] torque;
      logic [15:0]        rpm;
      logic signed [8:0]  temp;
      logic               ok;
      logic [15:0]        bleed;
      logic [15:0]        fill;
      logic [15:0]        overlap;
      logic [15:0]        start_t;
      logic [15:0]        flare;
   } shift_request_type;

   typedef struct {
      status_type         status;
      logic               hit;
      logic signed [15:0] spc;
      logic signed [15:0] mpc;
      logic signed [15:0] tim;
      phase_type          start_phase;
      phase_type          flare_phase;
   } fill_result_type;

   typedef struct {
      int spc;
      int mpc;
      int tim;
   } adder_set_type;

   class fill_table_book_type;
      int                rows;
      adder_set_type     cells[];
      int                max_torque;
      int                rpm_limit;
      int                temp_low;
      int                temp_high;
      int                def_spc;
      int                def_mpc;
      int                def_tim;
      fill_result_type   due_results[$];
      int                errors;

      function new(int n_rows);
         rows       = n_rows;
         cells      = new[n_rows * NUM_BANDS];
         foreach (cells[i]) cells[i] = '{0, 0, 0};
         max_torque = 400;
         rpm_limit  = 2500;
         temp_low   = 60;
         temp_high  = 110;
         def_spc    = 0;
         def_mpc    = 0;
         def_tim    = 0;
         errors     = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [15:0] data);
         case (idx)
            REG_MAX_TORQUE: max_torque = int'(data);
            REG_RPM_LIMIT:  rpm_limit  = int'(data);
            REG_TEMP_LOW:   temp_low   = int'($signed(data[8:0]));
            REG_TEMP_HIGH:  temp_high  = int'($signed(data[8:0]));
            REG_DEF_SPC:    def_spc    = int'($signed(data));
            REG_DEF_MPC:    def_mpc    = int'($signed(data));
            REG_DEF_TIME:   def_tim    = int'($signed(data));
            default: ;
         endcase
      endfunction

      // Row from the gear change, column from the torque band; -1 on a miss.
      function int cell_of(logic [3:0] change, logic signed [15:0] torque);
         int q;
         int t;
         int band;
         q = max_torque >> 2;
         t = int'(torque);
         if (int'(change) >= rows) return -1;
         if (t <= 0) band = 0;
         else if (t <= q) band = 1;
         else if (t <= 2 * q) band = 2;
         else if (t <= 3 * q) band = 3;
         else return -1;
         return int'(change) * NUM_BANDS + band;
      endfunction

      function phase_type phase_at(int t, int b_fill, int b_ovl, int b_max);
         if (t < b_fill) return PH_BEFORE_FILL;
         if (t < b_ovl) return PH_FILL;
         if (t < b_max) return PH_OVERLAP;
         if (t > b_max) return PH_AFTER;
         return PH_BOUNDARY;
      endfunction

      function int capped_add(int a, int b);
         int s;
         s = a + b;
         return (s > int'(ADDER_MAX)) ? int'(ADDER_MAX) : s;
      endfunction

      function void note_request(shift_request_type r);
         fill_result_type res;
         int idx;
         int temp;
         int b_fill;
         int b_ovl;
         int b_max;
         res.status      = ST_OK;
         res.hit         = 1'b0;
         res.spc         = 16'(def_spc);
         res.mpc         = 16'(def_mpc);
         res.tim         = 16'(def_tim);
         res.start_phase = PH_NONE;
         res.flare_phase = PH_NONE;
         temp            = int'(r.temp);
         case (r.cmd)
            CMD_CLEAR: begin
               foreach (cells[i]) cells[i] = '{def_spc, def_mpc, def_tim};
            end
            CMD_ADAPT: begin
               if (!r.ok) res.status = ST_INVALID;
               else if (int'(r.rpm) > rpm_limit) res.status = ST_RPM_HIGH;
               else if (temp < temp_low || temp > temp_high) res.status = ST_TEMP_OUT;
               else begin
                  idx = cell_of(r.change, r.torque);
                  if (idx < 0) begin
                     res.status = ST_NO_CELL;
                  end else begin
                     b_fill = int'(r.bleed);
                     b_ovl  = b_fill + int'(r.fill);
                     b_max  = b_ovl + int'(r.overlap);
                     res.start_phase = phase_at(int'(r.start_t), b_fill, b_ovl, b_max);
                     case (res.start_phase)
                        PH_BEFORE_FILL: begin
                           if (r.flare != 16'd0)
                              cells[idx].mpc = capped_add(cells[idx].mpc,
                                                          int'(INC_LARGE));
                           else
                              cells[idx].tim = capped_add(cells[idx].tim,
                                                          int'(INC_SMALL));
                        end
                        PH_AFTER: cells[idx].spc = capped_add(cells[idx].spc,
                                                              int'(INC_LARGE));
                        default: ;
                     endcase
                     if (r.flare != 16'd0)
                        res.flare_phase = phase_at(int'(r.flare), b_fill, b_ovl, b_max);
                     res.hit = 1'b1;
                     res.spc = 16'(cells[idx].spc);
                     res.mpc = 16'(cells[idx].mpc);
                     res.tim = 16'(cells[idx].tim);
                  end
               end
            end
            default: begin
               idx = cell_of(r.change, r.torque);
               if (idx < 0) begin
                  res.status = ST_NO_CELL;
               end else begin
                  res.hit = 1'b1;
                  res.spc = 16'(cells[idx].spc);
                  res.mpc = 16'(cells[idx].mpc);
                  res.tim = 16'(cells[idx].tim);
               end
            end
         endcase
         due_results.push_back(res);
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s is %h, expected %h", name, got, want));
      endtask

      task check_response(fill_result_type got);
         fill_result_type want;
         if (due_results.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = due_results.pop_front();
         compare_field("status", 16'(got.status), 16'(want.status));
         compare_field("cell_hit", 16'(got.hit), 16'(want.hit));
         compare_field("spc_adder", got.spc, want.spc);
         compare_field("mpc_adder", got.mpc, want.mpc);
         compare_field("time_adder", got.tim, want.tim);
         compare_field("start_phase", 16'(got.start_phase), 16'(want.start_phase));
         compare_field("flare_phase", 16'(got.flare_phase), 16'(want.flare_phase));
      endtask
   endclass

   localparam int TABLE_ROWS       = 8;
   localparam int CLOCK_PERIOD     = 12;
   localparam int RESET_CYCLES     = 11;
   localparam int RANDOM_PER_PHASE = 262;
   localparam int DRAIN_CYCLES     = 8;
   localparam int SETTLE_LIMIT     = 2000;
   localparam int CYCLE_LIMIT      = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   shift_request_type  drive;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic               rsp_cell_hit;
   logic signed [15:0] rsp_spc_adder;
   logic signed [15:0] rsp_mpc_adder;
   logic signed [15:0] rsp_time_adder;
   logic [2:0]         rsp_start_phase;
   logic [2:0]         rsp_flare_phase;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [15:0]        csr_data;

   fill_table_book_type book;
   int                  idle_pct = 0;
   int                  cycles = 0;

   shift_fill_adaptation_table_unit #(
      .NUM_CHANGES (TABLE_ROWS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (drive.cmd),
      .req_change_code   (drive.change),
      .req_static_torque (drive.torque),
      .req_engine_speed  (drive.rpm),
      .req_fluid_temp    (drive.temp),
      .req_report_ok     (drive.ok),
      .req_bleed_ms      (drive.bleed),
      .req_fill_ms       (drive.fill),
      .req_overlap_ms    (drive.overlap),
      .req_start_time    (drive.start_t),
      .req_flare_time    (drive.flare),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_cell_hit      (rsp_cell_hit),
      .rsp_spc_adder     (rsp_spc_adder),
      .rsp_mpc_adder     (rsp_mpc_adder),
      .rsp_time_adder    (rsp_time_adder),
      .rsp_start_phase   (rsp_start_phase),
      .rsp_flare_phase   (rsp_flare_phase),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Bound the run: a hung handshake ends here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // Record every request transfer; the scoreboard predicts its response now,
   // so table state advances in transfer order.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         book.note_request(drive);
   end

   // Capture every response strobe; the unit cannot be held off.
   always @(posedge clock) begin
      fill_result_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.status      = status_type'(rsp_status);
         got.hit         = rsp_cell_hit;
         got.spc         = rsp_spc_adder;
         got.mpc         = rsp_mpc_adder;
         got.tim         = rsp_time_adder;
         got.start_phase = phase_type'(rsp_start_phase);
         got.flare_phase = phase_type'(rsp_flare_phase);
         book.check_response(got);
      end
   end

   function automatic shift_request_type shift_req(cmd_type cmd, int change, int torque,
                                                   int rpm, int temp, bit ok, int bleed,
                                                   int fill, int overlap, int st, int fl);
      shift_request_type r;
      r.cmd     = cmd;
      r.change  = 4'(change);
      r.torque  = 16'(torque);
      r.rpm     = 16'(rpm);
      r.temp    = 9'(temp);
      r.ok      = ok;
      r.bleed   = 16'(bleed);
      r.fill    = 16'(fill);
      r.overlap = 16'(overlap);
      r.start_t = 16'(st);
      r.flare   = 16'(fl);
      return r;
   endfunction

   // Land an instant on or next to a phase boundary most of the time.
   function automatic logic [15:0] pick_instant(int b_fill, int b_ovl, int b_max);
      int v;
      case ($urandom_range(7))
         0: v = int'($urandom);
         1: v = b_fill - 1;
         2: v = b_fill;
         3: v = b_ovl;
         4: v = b_max - 1;
         5: v = b_max;
         6: v = b_max + 1;
         default: v = int'($urandom_range(b_max + 20));
      endcase
      return 16'(v);
   endfunction

   // Mostly well-formed adapt reports that pass the checks and hit a cell,
   // spread with lookups, a few clears and some noise.
   function automatic shift_request_type random_request();
      shift_request_type r;
      int pick;
      int q;
      int v;
      int b_fill;
      int b_ovl;
      int b_max;
      pick = $urandom_range(99);
      if (pick < 3) r.cmd = CMD_CLEAR;
      else if (pick < 8) r.cmd = CMD_SPARE;
      else if (pick < 45) r.cmd = CMD_LOOKUP;
      else r.cmd = CMD_ADAPT;
      if ($urandom_range(99) < 85) r.change = 4'($urandom_range(TABLE_ROWS - 1));
      else r.change = 4'($urandom_range(15, TABLE_ROWS));
      q = book.max_torque >> 2;
      case ($urandom_range(5))
         0: v = int'($signed(16'($urandom)));
         1: v = 0;
         5: v = int'($urandom_range(3 * q + 1));
         default: v = q * int'($urandom_range(3)) + int'($urandom_range(2)) - 1;
      endcase
      if (v > 32767) v = 32767;
      r.torque = 16'(v);
      if ($urandom_range(99) < 88) r.rpm = 16'($urandom_range(book.rpm_limit));
      else r.rpm = 16'($urandom);
      if ($urandom_range(99) < 88 && book.temp_low <= book.temp_high)
         v = book.temp_low + int'($urandom_range(book.temp_high - book.temp_low));
      else
         v = int'($urandom_range(240)) - 40;
      r.temp = 9'(v);
      r.ok = ($urandom_range(99) < 92);
      if ($urandom_range(99) < 85) begin
         r.bleed   = 16'($urandom_range(300));
         r.fill    = 16'($urandom_range(300));
         r.overlap = 16'($urandom_range(300));
      end else begin
         r.bleed   = 16'($urandom);
         r.fill    = 16'($urandom);
         r.overlap = 16'($urandom);
      end
      b_fill  = int'(r.bleed);
      b_ovl   = b_fill + int'(r.fill);
      b_max   = b_ovl + int'(r.overlap);
      r.start_t = pick_instant(b_fill, b_ovl, b_max);
      r.flare = ($urandom_range(99) < 45) ? 16'd0 : pick_instant(b_fill, b_ovl, b_max);
      return r;
   endfunction

   // Present one request from a falling edge and hold it until it transfers.
   // Idle gaps drop start first; back-to-back requests keep start high.
   task automatic send_request(shift_request_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      drive = r;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      book.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic program_settings(int torque_max, int rpm_max, int t_low, int t_high,
                                   int d_spc, int d_mpc, int d_tim);
      write_reg(REG_MAX_TORQUE, 16'(torque_max));
      write_reg(REG_RPM_LIMIT, 16'(rpm_max));
      write_reg(REG_TEMP_LOW, 16'(t_low));
      write_reg(REG_TEMP_HIGH, 16'(t_high));
      write_reg(REG_DEF_SPC, 16'(d_spc));
      write_reg(REG_DEF_MPC, 16'(d_mpc));
      write_reg(REG_DEF_TIME, 16'(d_tim));
      // The spare index must drop the write.
      write_reg(REG_UNUSED, 16'($urandom));
   endtask

   // Drop start, wait for every outstanding response, then let the pipe empty.
   task automatic settle();
      int waited = 0;
      @(negedge clock);
      start = 1'b0;
      while (book.due_results.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (book.due_results.size() != 0) begin
         book.report($sformatf("%0d responses never arrived", book.due_results.size()));
         book.due_results.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count, int gap_pct);
      idle_pct = gap_pct;
      repeat (count) send_request(random_request());
   endtask

   initial begin
      int t_low;
      book      = new(TABLE_ROWS);
      reset     = 1'b1;
      start     = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_MAX_TORQUE;
      csr_data  = 16'd0;
      drive     = shift_req(CMD_LOOKUP, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opener at reset settings: quarter torque 100, rpm up to
      // 2500, fluid 60..110 C, defaults all zero.
      idle_pct = 0;
      send_request(shift_req(CMD_LOOKUP, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_LOOKUP, 15, 50, 0, 0, 1'b1, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_LOOKUP, 7, 300, 0, 0, 1'b1, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_LOOKUP, 7, 301, 0, 0, 1'b1, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_LOOKUP, 3, -32768, 0, 0, 1'b1, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_SPARE, 2, 32767, 65535, 200, 1'b1, 1, 1, 1, 1, 1));
      // Rejections in check order: invalid report, speed, temperature, cell.
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 80, 1'b0, 10, 10, 10, 0, 0));
      send_request(shift_req(CMD_ADAPT, 2, 100, 2501, 80, 1'b1, 10, 10, 10, 0, 0));
      send_request(shift_req(CMD_ADAPT, 2, 100, 2500, 59, 1'b1, 10, 10, 10, 0, 0));
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 111, 1'b1, 10, 10, 10, 0, 0));
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, -40, 1'b1, 10, 10, 10, 0, 0));
      send_request(shift_req(CMD_ADAPT, 1, 301, 1000, 80, 1'b1, 10, 10, 10, 0, 0));
      send_request(shift_req(CMD_ADAPT, 8, 50, 1000, 60, 1'b1, 10, 10, 10, 0, 0));
      // Start phases before fill, fill, boundary and after, with and without flare.
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 110, 1'b1, 100, 50, 50, 99, 0));
      send_request(shift_req(CMD_ADAPT, 2, 100, 0, 80, 1'b1, 100, 50, 50, 99, 99));
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 80, 1'b1, 100, 50, 50, 100, 150));
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 80, 1'b1, 100, 50, 50, 200, 250));
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 80, 1'b1, 100, 50, 50, 201, 1));
      // Boundary sums past 16 bits, and all-zero phases.
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 80, 1'b1,
                             65535, 65535, 65535, 65535, 65535));
      send_request(shift_req(CMD_ADAPT, 2, 100, 1000, 80, 1'b1, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_LOOKUP, 2, 100, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      send_request(shift_req(CMD_LOOKUP, 2, 100, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      run_random(RANDOM_PER_PHASE, 0);
      settle();

      // Widest window, spc and time defaults near the top: adders saturate.
      program_settings(65535, 65535, -40, 200, 32767, -32768, 32750);
      send_request(shift_req(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0));
      repeat (2) send_request(shift_req(CMD_ADAPT, 0, 0, 0, 25, 1'b1, 10, 10, 10, 40, 0));
      repeat (2) send_request(shift_req(CMD_ADAPT, 0, 0, 0, 25, 1'b1, 10, 10, 10, 5, 0));
      run_random(RANDOM_PER_PHASE, 72);
      settle();

      // Narrowest settings: only non-positive torque hits, only standstill
      // and 200 C adapt.
      program_settings(0, 0, 200, 200, -32768, 32767, -1);
      run_random(RANDOM_PER_PHASE, 0);
      settle();

      // Ordinary random settings with moderate idling.
      t_low = int'($urandom_range(60)) - 40;
      program_settings(int'($urandom_range(2000, 100)), int'($urandom_range(6000, 1000)),
                       t_low, t_low + int'($urandom_range(100)),
                       int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                       int'($signed(16'($urandom))));
      run_random(RANDOM_PER_PHASE, 34);
      settle();

      if (book.errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
